/* hw/rtl/pip_pkg.sv */
// Package for the point-in-polyhedron tester: sizes, codes and word types.
// Used by the channel interfaces, the top level and the checker.
package pip_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int MAX_CORNERS      = 64;
  localparam int MAX_FACE_ENTRIES = 256;

  localparam int CRN_AW  = $clog2(MAX_CORNERS);
  localparam int FACE_AW = $clog2(MAX_FACE_ENTRIES);
  localparam int FCNT_W  = 9;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int COF_W   = 2 * DIFF_W + 1;
  localparam int ACC_W   = COF_W + DIFF_W + 2;
  localparam int BIT_W   = $clog2(DIFF_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_APEX_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APEX_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APEX_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_ENTRIES = 3'd5;

  typedef enum logic [1:0] {
    ACT_CORNER = 2'd0,
    ACT_FACE   = 2'd1,
    ACT_TEST   = 2'd2
  } action_e;

  typedef logic [2:0][COORD_WIDTH-1:0] point_t;

  typedef struct packed {
    action_e                        action;
    logic [7:0]                     slot;
    logic signed [COORD_WIDTH-1:0]  coord_x;
    logic signed [COORD_WIDTH-1:0]  coord_y;
    logic signed [COORD_WIDTH-1:0]  coord_z;
    logic [5:0]                     face_corner;
    logic                           face_last;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } out_word_t;

endpackage

/* hw/rtl/pip_if.sv */
// Valid/ready channel interfaces for the point-in-polyhedron tester.
// Depends on pip_pkg for the word types.
interface pip_in_if;
  logic              valid;
  logic              ready;
  pip_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pip_out_if;
  logic               valid;
  logic               ready;
  pip_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/point_in_polyhedron_test.sv */
// Point-in-polyhedron tester with a bit-serial multiply-accumulate unit.
// A write word is taken without stalling the input. A test evaluates up to five determinants
// per tetrahedron (nine serial products per determinant) after reading its corners, and walks
// the face entries one at a time to form each tetrahedron.
// One word is worked on at a time. Reset clears the registers and control state;
// the corner and face tables hold garbage until written. Depends on pip_pkg, pip_if.
module point_in_polyhedron_test (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pip_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pip_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pip_in_if.sink                         in_i,
  pip_out_if.source                      out_o
);
  import pip_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_FACE_RD = 4'd1;
  localparam logic [3:0] ST_FACE_EV = 4'd2;
  localparam logic [3:0] ST_NEXT    = 4'd3;
  localparam logic [3:0] ST_CRN_RD  = 4'd4;
  localparam logic [3:0] ST_CRN_WR  = 4'd5;
  localparam logic [3:0] ST_LOAD    = 4'd6;
  localparam logic [3:0] ST_MUL     = 4'd7;
  localparam logic [3:0] ST_VOL     = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0]             state_q;
  point_t                 apex_q;
  logic [6:0]             corner_cnt_q;
  logic [6:0]             face_cnt_q;
  logic [FCNT_W-1:0]      fec_q;

  point_t                 crn_mem [MAX_CORNERS];
  logic [6:0]             face_mem [MAX_FACE_ENTRIES];
  point_t                 crn_rd_q;
  logic [6:0]             face_rd_q;
  logic [CRN_AW-1:0]      crn_addr;

  point_t                 p_q;
  point_t                 tv_q [4];
  logic                   single_q;
  logic [FCNT_W-1:0]      i_q;
  logic [FCNT_W-1:0]      n_q;
  logic [1:0]             pos_q;
  logic [CRN_AW-1:0]      first_q;
  logic [CRN_AW-1:0]      prev_q;
  logic [CRN_AW-1:0]      cur_q;
  logic                   last_q;
  logic [1:0]             cnt_q;
  logic [2:0]             sub_q;
  logic [3:0]             s_q;
  logic                   st_neg_q;

  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  mcand_q;
  logic [DIFF_W-1:0]        mplier_q;
  logic                     neg_q;
  logic [BIT_W-1:0]         bit_q;
  logic signed [COF_W-1:0]  c0_q;
  logic signed [COF_W-1:0]  c1_q;
  logic signed [COF_W-1:0]  c2_q;

  out_word_t              pend_q;
  out_word_t              res_q;
  logic                   out_valid_q;

  logic                   in_acc;
  point_t                 in_pt;
  point_t                 q [4];
  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];
  logic signed [DIFF_W-1:0] w [3];
  logic signed [ACC_W-1:0]  mc_sel;
  logic [DIFF_W-1:0]        mp_sel;
  logic                     neg_sel;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_d;
  logic                     bit_last;
  logic                     fetch_end;
  logic [1:0]               pos_d;

  function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_WIDTH-1:0] a,
                                                   input logic [COORD_WIDTH-1:0] b);
    return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
  endfunction

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;
  assign in_pt = {in_i.data.coord_z, in_i.data.coord_y, in_i.data.coord_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apex_q       <= '0;
      corner_cnt_q <= '0;
      face_cnt_q   <= '0;
      fec_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_APEX_X:       apex_q[0]    <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_APEX_Y:       apex_q[1]    <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_APEX_Z:       apex_q[2]    <= cfg_data_i[COORD_WIDTH-1:0];
        CFG_CORNER_COUNT: corner_cnt_q <= cfg_data_i[6:0];
        CFG_FACE_COUNT:   face_cnt_q   <= cfg_data_i[6:0];
        CFG_FACE_ENTRIES: fec_q        <= cfg_data_i[FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.data.action == ACT_CORNER && int'(in_i.data.slot) < MAX_CORNERS) begin
      crn_mem[in_i.data.slot[CRN_AW-1:0]] <= in_pt;
    end
    if (in_acc && in_i.data.action == ACT_FACE &&
        int'(in_i.data.slot) < MAX_FACE_ENTRIES) begin
      face_mem[in_i.data.slot[FACE_AW-1:0]] <= {in_i.data.face_last, in_i.data.face_corner};
    end
    crn_rd_q  <= crn_mem[crn_addr];
    face_rd_q <= face_mem[i_q[FACE_AW-1:0]];
  end

  always_comb begin
    if (single_q) begin
      crn_addr = CRN_AW'(cnt_q);
    end else begin
      unique case (cnt_q)
        2'd0:    crn_addr = first_q;
        2'd1:    crn_addr = prev_q;
        default: crn_addr = cur_q;
      endcase
    end
    fetch_end = single_q ? (cnt_q == 2'd3) : (cnt_q == 2'd2);
    pos_d = last_q ? 2'd0 : ((pos_q == 2'd2) ? 2'd2 : pos_q + 2'd1);
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      q[j] = (sub_q == 3'(j + 1)) ? p_q : tv_q[j];
    end
    for (int k = 0; k < 3; k++) begin
      u[k] = diff(q[1][k], q[0][k]);
      v[k] = diff(q[2][k], q[0][k]);
      w[k] = diff(q[3][k], q[0][k]);
    end
    unique case (s_q)
      4'd0: begin mc_sel = ACC_W'(v[1]); mp_sel = w[2]; neg_sel = 1'b0; end
      4'd1: begin mc_sel = ACC_W'(v[2]); mp_sel = w[1]; neg_sel = 1'b1; end
      4'd2: begin mc_sel = ACC_W'(v[0]); mp_sel = w[2]; neg_sel = 1'b0; end
      4'd3: begin mc_sel = ACC_W'(v[2]); mp_sel = w[0]; neg_sel = 1'b1; end
      4'd4: begin mc_sel = ACC_W'(v[0]); mp_sel = w[1]; neg_sel = 1'b0; end
      4'd5: begin mc_sel = ACC_W'(v[1]); mp_sel = w[0]; neg_sel = 1'b1; end
      4'd6: begin mc_sel = ACC_W'(c0_q); mp_sel = u[0]; neg_sel = 1'b0; end
      4'd7: begin mc_sel = ACC_W'(c1_q); mp_sel = u[1]; neg_sel = 1'b1; end
      4'd8: begin mc_sel = ACC_W'(c2_q); mp_sel = u[2]; neg_sel = 1'b0; end
      default: begin mc_sel = '0; mp_sel = '0; neg_sel = 1'b0; end
    endcase
    bit_last = (bit_q == BIT_W'(DIFF_W - 1));
    term  = mplier_q[0] ? mcand_q : '0;
    acc_d = (neg_q ^ bit_last) ? acc_q - term : acc_q + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      pend_q      <= '0;
      p_q         <= '0;
      for (int j = 0; j < 4; j++) tv_q[j] <= '0;
      single_q    <= 1'b0;
      i_q         <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      sub_q       <= '0;
      s_q         <= '0;
      st_neg_q    <= 1'b0;
      acc_q       <= '0;
      mcand_q     <= '0;
      mplier_q    <= '0;
      neg_q       <= 1'b0;
      bit_q       <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_i.data.action == ACT_TEST) begin
            p_q   <= in_pt;
            cnt_q <= '0;
            sub_q <= '0;
            s_q   <= '0;
            i_q   <= '0;
            pos_q <= '0;
            if (corner_cnt_q == 7'd4 && face_cnt_q == 7'd4) begin
              single_q <= 1'b1;
              state_q  <= ST_CRN_RD;
            end else begin
              single_q <= 1'b0;
              tv_q[3]  <= apex_q;
              n_q <= (int'(fec_q) > MAX_FACE_ENTRIES) ? FCNT_W'(MAX_FACE_ENTRIES) : fec_q;
              if (fec_q == '0) begin
                pend_q  <= '0;
                state_q <= ST_DONE;
              end else begin
                state_q <= ST_FACE_RD;
              end
            end
          end
        end
        ST_FACE_RD: state_q <= ST_FACE_EV;
        ST_FACE_EV: begin
          cur_q  <= face_rd_q[CRN_AW-1:0];
          last_q <= face_rd_q[6];
          if (pos_q == 2'd0) begin
            first_q <= face_rd_q[CRN_AW-1:0];
          end
          if (pos_q == 2'd2) begin
            cnt_q   <= '0;
            sub_q   <= '0;
            s_q     <= '0;
            state_q <= ST_CRN_RD;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          prev_q <= cur_q;
          pos_q  <= pos_d;
          i_q    <= i_q + 1'b1;
          if (i_q + 1'b1 >= n_q) begin
            pend_q  <= '0;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_FACE_RD;
          end
        end
        ST_CRN_RD: state_q <= ST_CRN_WR;
        ST_CRN_WR: begin
          tv_q[cnt_q] <= crn_rd_q;
          cnt_q <= cnt_q + 2'd1;
          state_q <= fetch_end ? ST_LOAD : ST_CRN_RD;
        end
        ST_LOAD: begin
          mcand_q  <= mc_sel;
          mplier_q <= mp_sel;
          neg_q    <= neg_sel;
          bit_q    <= '0;
          if (s_q == 4'd0 || s_q == 4'd2 || s_q == 4'd4 || s_q == 4'd6) begin
            acc_q <= '0;
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          acc_q    <= acc_d;
          mcand_q  <= mcand_q <<< 1;
          mplier_q <= mplier_q >> 1;
          bit_q    <= bit_q + 1'b1;
          if (bit_last) begin
            if (s_q == 4'd1) c0_q <= acc_d[COF_W-1:0];
            if (s_q == 4'd3) c1_q <= acc_d[COF_W-1:0];
            if (s_q == 4'd5) c2_q <= acc_d[COF_W-1:0];
            if (s_q == 4'd8) begin
              state_q <= ST_VOL;
            end else begin
              s_q     <= s_q + 4'd1;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_VOL: begin
          s_q <= '0;
          if (sub_q == 3'd0) begin
            if (acc_q == '0) begin
              pend_q  <= '{inside_res: 1'b0, degenerate: 1'b1};
              state_q <= ST_DONE;
            end else begin
              st_neg_q <= acc_q[ACC_W-1];
              sub_q    <= 3'd1;
              state_q  <= ST_LOAD;
            end
          end else if (acc_q != '0 && acc_q[ACC_W-1] != st_neg_q) begin
            if (single_q) begin
              pend_q  <= '0;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_NEXT;
            end
          end else if (sub_q == 3'd4) begin
            pend_q  <= '{inside_res: 1'b1, degenerate: 1'b0};
            state_q <= ST_DONE;
          end else begin
            sub_q   <= sub_q + 3'd1;
            state_q <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            res_q       <= pend_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/pip_checker.sv */
// Port-level checker for the point-in-polyhedron tester, bound to the top level.
// Depends on pip_pkg for the action codes.
module pip_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input pip_pkg::action_e   in_action_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input pip_pkg::out_word_t out_data_i
);
  import pip_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result word dropped before it was taken.");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ACT_TEST |=> !in_ready_i)
    else $error("Input still ready after a test word was taken.");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i != ACT_TEST |=> in_ready_i)
    else $error("Table write stalled the input.");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("Result appeared without a test in progress.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_data_i.inside_res && out_data_i.degenerate))
    else $error("Inside and degenerate flags both set.");

endmodule

bind point_in_polyhedron_test pip_checker u_pip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.data.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

/* test/tb_point_in_polyhedron_test.sv */
// Self-checking testbench for the point-in-polyhedron tester: loads tables, sweeps settings,
// predicts each test result and checks every returned word. Depends on pip_pkg and pip_if.
module tb_point_in_polyhedron_test;
  import pip_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 12;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } pnt_t;

  typedef enum int {TET_OUT, TET_IN, TET_DEGEN} tet_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pip_in_if in_ch ();
  pip_out_if out_ch ();

  point_in_polyhedron_test dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  // Local copy of the block's tables and registers.
  pnt_t corner_mem [MAX_CORNERS];
  logic [6:0] face_mem [MAX_FACE_ENTRIES];
  pnt_t apex_pt;
  int unsigned n_corners, n_faces, n_entries;

  out_word_t result_q[$];
  int errors = 0;
  int n_results = 0;
  int n_inside = 0;
  int n_degen = 0;
  bit bursty;
  int burst_left;
  bit stall_on;
  logic [15:0] rdy_pat;
  logic [3:0] cyc = '0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint vol6(pnt_t a, pnt_t b, pnt_t c, pnt_t d);
    longint u0 = longint'(b.x) - longint'(a.x);
    longint u1 = longint'(b.y) - longint'(a.y);
    longint u2 = longint'(b.z) - longint'(a.z);
    longint v0 = longint'(c.x) - longint'(a.x);
    longint v1 = longint'(c.y) - longint'(a.y);
    longint v2 = longint'(c.z) - longint'(a.z);
    longint w0 = longint'(d.x) - longint'(a.x);
    longint w1 = longint'(d.y) - longint'(a.y);
    longint w2 = longint'(d.z) - longint'(a.z);
    return u0 * (v1 * w2 - v2 * w1) - u1 * (v0 * w2 - v2 * w0) + u2 * (v0 * w1 - v1 * w0);
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic tet_e classify_tet(pnt_t a, pnt_t b, pnt_t c, pnt_t d, pnt_t p);
    int st;
    int s [4];
    st = sign_of(vol6(a, b, c, d));
    if (st == 0) return TET_DEGEN;
    s[0] = sign_of(vol6(p, b, c, d));
    s[1] = sign_of(vol6(a, p, c, d));
    s[2] = sign_of(vol6(a, b, p, d));
    s[3] = sign_of(vol6(a, b, c, p));
    foreach (s[k]) if (s[k] != 0 && s[k] != st) return TET_OUT;
    return TET_IN;
  endfunction

  function automatic out_word_t containment(pnt_t p);
    out_word_t r;
    tet_e t;
    int n, pos;
    logic [5:0] first, prev, cur;
    t = TET_OUT;
    pos = 0;
    first = '0;
    prev = '0;
    if (n_corners == 4 && n_faces == 4) begin
      t = classify_tet(corner_mem[0], corner_mem[1], corner_mem[2], corner_mem[3], p);
    end else begin
      n = (n_entries > MAX_FACE_ENTRIES) ? MAX_FACE_ENTRIES : n_entries;
      for (int i = 0; i < n && t == TET_OUT; i++) begin
        cur = face_mem[i][5:0];
        if (pos == 0) first = cur;
        if (pos >= 2) t = classify_tet(corner_mem[first], corner_mem[prev], corner_mem[cur],
                                       apex_pt, p);
        prev = cur;
        pos = face_mem[i][6] ? 0 : pos + 1;
      end
    end
    r.inside_res = (t == TET_IN);
    r.degenerate = (t == TET_DEGEN);
    return r;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord(int span);
    if (span == 0) return COORD_WIDTH'($urandom);
    return COORD_WIDTH'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic in_word_t corner_word(int slot, int x, int y, int z);
    in_word_t w;
    w = '0;
    w.face_corner = 6'($urandom);
    w.face_last = 1'($urandom);
    w.action = ACT_CORNER;
    w.slot = 8'(slot);
    w.coord_x = COORD_WIDTH'(x);
    w.coord_y = COORD_WIDTH'(y);
    w.coord_z = COORD_WIDTH'(z);
    return w;
  endfunction

  function automatic in_word_t face_word(int slot, int crn, bit last);
    in_word_t w;
    w.action = ACT_FACE;
    w.slot = 8'(slot);
    w.coord_x = COORD_WIDTH'($urandom);
    w.coord_y = COORD_WIDTH'($urandom);
    w.coord_z = COORD_WIDTH'($urandom);
    w.face_corner = 6'(crn);
    w.face_last = last;
    return w;
  endfunction

  function automatic in_word_t test_word(int x, int y, int z);
    in_word_t w;
    w = corner_word($urandom, x, y, z);
    w.action = ACT_TEST;
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    case (idx)
      CFG_APEX_X: apex_pt.x = COORD_WIDTH'(value);
      CFG_APEX_Y: apex_pt.y = COORD_WIDTH'(value);
      CFG_APEX_Z: apex_pt.z = COORD_WIDTH'(value);
      CFG_CORNER_COUNT: n_corners = value & 'h7f;
      CFG_FACE_COUNT: n_faces = value & 'h7f;
      CFG_FACE_ENTRIES: n_entries = value & 'h1ff;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int ax, int ay, int az, int nc, int nf, int ne);
    write_reg(CFG_APEX_X, ax);
    write_reg(CFG_APEX_Y, ay);
    write_reg(CFG_APEX_Z, az);
    write_reg(CFG_CORNER_COUNT, nc);
    write_reg(CFG_FACE_COUNT, nf);
    write_reg(CFG_FACE_ENTRIES, ne);
  endtask

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    case (w.action)
      ACT_CORNER: if (w.slot < MAX_CORNERS)
        corner_mem[w.slot[CRN_AW-1:0]] = {w.coord_x, w.coord_y, w.coord_z};
      ACT_FACE: face_mem[w.slot] = {w.face_last, w.face_corner};
      ACT_TEST: result_q.push_back(containment({w.coord_x, w.coord_y, w.coord_z}));
      default: ;
    endcase
  endtask

  // Stops sending, waits for every pending result and lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_empty_tables();
    send_word(test_word(0, 0, 0));
    send_word(test_word(-32768, 32767, -1));
    drain();
  endtask

  task automatic load_tables();
    for (int i = 0; i < MAX_CORNERS; i++)
      send_word(corner_word(i, rand_coord(200), rand_coord(200), rand_coord(200)));
    drain();
  endtask

  task automatic test_single_tet();
    configure(0, 0, 0, 4, 4, 0);
    send_word(corner_word(0, 0, 0, 0));
    send_word(corner_word(1, 1000, 0, 0));
    send_word(corner_word(2, 0, 1000, 0));
    send_word(corner_word(3, 0, 0, 1000));
    send_word(test_word(100, 100, 100));
    send_word(test_word(0, 0, 0));
    send_word(test_word(500, 500, 0));
    send_word(test_word(600, 600, 0));
    send_word(test_word(32767, 32767, 32767));
    send_word(test_word(-32768, -32768, -32768));
    send_word(corner_word(3, 500, 500, 0));
    send_word(test_word(100, 100, 0));
    send_word(corner_word(0, -32768, -32768, -32768));
    send_word(corner_word(1, 32767, -32768, -32768));
    send_word(corner_word(2, -32768, 32767, -32768));
    send_word(corner_word(3, -32768, -32768, 32767));
    send_word(test_word(0, 0, 0));
    send_word(test_word(32767, 32767, 32767));
    send_word(test_word(-32768, -32768, -32768));
    drain();
  endtask

  task automatic test_fan_cube();
    int quads [24] = '{0, 2, 6, 4, 1, 3, 7, 5, 0, 1, 5, 4, 2, 3, 7, 6, 0, 1, 3, 2, 4, 5, 7, 6};
    configure(0, 0, 0, 8, 6, 24);
    for (int i = 0; i < 8; i++)
      send_word(corner_word(i, i[0] ? 100 : -100, i[1] ? 100 : -100, i[2] ? 100 : -100));
    foreach (quads[i]) send_word(face_word(i, quads[i], i % 4 == 3));
    send_word(test_word(10, 20, 30));
    send_word(test_word(100, 100, 100));
    send_word(test_word(150, 0, 0));
    send_word(test_word(0, 0, 0));
    drain();
    // Apex on the x+ face makes its fanned tetrahedra flat.
    configure(100, 0, 0, 8, 6, 24);
    send_word(test_word(-50, 0, 0));
    send_word(test_word(0, 0, 500));
    send_word(test_word(100, 0, 0));
    drain();
  endtask

  task automatic test_odd_faces();
    configure(0, 0, 300, 8, 4, 6);
    send_word(corner_word(40, 30, 200, 0));
    send_word(face_word(0, 0, 1'b1));
    send_word(face_word(1, 1, 1'b0));
    send_word(face_word(2, 2, 1'b1));
    send_word(face_word(3, 0, 1'b0));
    send_word(face_word(4, 1, 1'b0));
    send_word(face_word(5, 40, 1'b0));
    send_word(test_word(0, 0, 50));
    send_word(test_word(0, 0, -50));
    drain();
    configure(0, 0, 1000, 8, 4, 511);
    send_word(face_word(0, 0, 1'b0));
    send_word(face_word(1, 1, 1'b0));
    send_word(face_word(2, 2, 1'b1));
    for (int i = 3; i < MAX_FACE_ENTRIES; i++) send_word(face_word(i, $urandom_range(0, 63), 1'b1));
    send_word(test_word(-20000, 0, 0));
    send_word(test_word(-90, -90, 5));
    drain();
    write_reg(CFG_FACE_ENTRIES, 300);
    send_word(test_word(-20000, 5, 5));
    drain();
  endtask

  task automatic test_ignored_words();
    send_word(corner_word(64, 1, 2, 3));
    send_word(corner_word(255, -1, -2, -3));
    begin
      in_word_t w;
      w = test_word(0, 0, 0);
      w.action = action_e'(ACT_UNUSED);
      send_word(w);
    end
    send_word(test_word(0, 0, 0));
    drain();
  endtask

  task automatic test_random();
    in_word_t w;
    int pick, span;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: configure(-32768, -32768, -32768, $urandom_range(0, 64), 4, $urandom_range(0, 12));
        1: configure(32767, 32767, 32767, $urandom_range(0, 64), 0, $urandom_range(0, 12));
        2: configure(rand_coord(300), rand_coord(300), rand_coord(300), 4, 4, 0);
        3: configure(rand_coord(300), rand_coord(300), rand_coord(300), 127, 127, $urandom_range(0, 12));
        default: configure(rand_coord(300), rand_coord(300), rand_coord(300),
                           $urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(0, 12));
      endcase
      bursty = (ph != 2);
      stall_on = ph[0];
      rdy_pat = 16'($urandom | 32'h1);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        span = ($urandom_range(0, 99) < 85) ? 200 : 0;
        if (pick < 35) begin
          w = corner_word(($urandom_range(0, 9) == 0) ? $urandom_range(64, 255) : $urandom_range(0, 63),
                          rand_coord(span), rand_coord(span), rand_coord(span));
        end else if (pick < 65) begin
          w = face_word(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15),
                        ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 63),
                        $urandom_range(0, 2) == 0);
        end else if (pick < 97) begin
          w = test_word(rand_coord(span), rand_coord(span), rand_coord(span));
        end else begin
          w = test_word(rand_coord(0), rand_coord(0), rand_coord(0));
          w.action = action_e'(ACT_UNUSED);
        end
        send_word(w);
      end
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1'b1;
    out_ch.ready <= stall_on ? rdy_pat[cyc] : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, out_ch.data);
        errors++;
      end else begin
        out_word_t exp_w;
        exp_w = result_q.pop_front();
        if (out_ch.data.inside_res !== exp_w.inside_res) begin
          $display("%0t: inside_res mismatch, expected %b, actual %b", $time,
                   exp_w.inside_res, out_ch.data.inside_res);
          errors++;
        end
        if (out_ch.data.degenerate !== exp_w.degenerate) begin
          $display("%0t: degenerate mismatch, expected %b, actual %b", $time,
                   exp_w.degenerate, out_ch.data.degenerate);
          errors++;
        end
        n_inside += exp_w.inside_res;
        n_degen += exp_w.degenerate;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    bursty = 1'b0;
    burst_left = 0;
    stall_on = 1'b0;
    rdy_pat = 16'hffff;
    apex_pt = '0;
    n_corners = 0;
    n_faces = 0;
    n_entries = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_tables();
    bursty = 1'b1;
    stall_on = 1'b1;
    rdy_pat = 16'h5b3d;
    load_tables();
    test_single_tet();
    test_fan_cube();
    test_odd_faces();
    test_ignored_words();
    test_random();
    $display("Checked %0d test results (%0d inside, %0d degenerate) over directed shapes",
             n_results, n_inside, n_degen);
    $display("and %0d random phases of %0d words each.", RANDOM_PHASES, WORDS_PER_PHASE);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
